FILE: rtl/sip_header_value_locator_assert.svh
// ---------------------------------------------------------------------------
// SIP header value locator assertion macros
// Shared concurrent assertion forms used by the locator modules.
// ---------------------------------------------------------------------------
`ifndef SIP_HEADER_VALUE_LOCATOR_ASSERT_SVH
`define SIP_HEADER_VALUE_LOCATOR_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define SHVL_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("shvl: invariant violated");

// A consequence that must hold in the same cycle as its cause.
`define SHVL_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("shvl: same-cycle implication violated");

// A consequence that must hold in the cycle after its cause.
`define SHVL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("shvl: next-cycle implication violated");

`endif

FILE: rtl/shvl_pkg.sv
// ---------------------------------------------------------------------------
// SIP header value locator package
// Types, codes and helper functions shared by the locator modules.
// ---------------------------------------------------------------------------
package shvl_pkg;

   localparam int LONG_NAME_LIMIT = 24;
   localparam int SHORT_NAME_BYTES = 8;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] CHAR_CR    = 8'h0d;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_COLON = 8'h3a;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_LONG_LOW   = 3'd0,
      CSR_LONG_MID   = 3'd1,
      CSR_LONG_HIGH  = 3'd2,
      CSR_LONG_LEN   = 3'd3,
      CSR_SHORT      = 3'd4,
      CSR_SHORT_LEN  = 3'd5,
      CSR_START      = 3'd6
   } csr_index_type;

   // Parser phases, one-hot.
   typedef enum logic [9:0] {
      PH_WAIT       = 10'b00_0000_0001,
      PH_SKIP       = 10'b00_0000_0010,
      PH_SKIP_CR    = 10'b00_0000_0100,
      PH_LINE_START = 10'b00_0000_1000,
      PH_NAME       = 10'b00_0001_0000,
      PH_POST_NAME  = 10'b00_0010_0000,
      PH_VAL_LWS    = 10'b00_0100_0000,
      PH_VAL_TEXT   = 10'b00_1000_0000,
      PH_VAL_CR     = 10'b01_0000_0000,
      PH_VAL_LF     = 10'b10_0000_0000
   } phase_type;

   typedef enum logic [1:0] {
      DEC_NONE = 2'd0,
      DEC_MISS = 2'd1,
      DEC_HIT  = 2'd2
   } decision_type;

   // Classification of one byte, produced by the front end.
   typedef struct packed {
      logic [7:0] folded;
      logic       blank;
      logic       cr;
      logic       lf;
      logic       colon;
      logic       content;
      logic       above_space;
      logic       final_byte;
      logic       too_long;
   } byte_class_type;

   // Configuration seen by the parser, apart from the long name bytes.
   typedef struct packed {
      logic [4:0]  long_len;
      logic [63:0] short_bytes;
      logic [3:0]  short_len;
      logic [15:0] start_offset;
   } cfg_type;

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5a) begin
         r = c + 8'd32;
      end
      return r;
   endfunction

endpackage

FILE: rtl/shvl_front.sv
// ---------------------------------------------------------------------------
// SIP header value locator front end
// Counts byte offsets within a message and classifies each accepted byte.
// ---------------------------------------------------------------------------
module shvl_front
   import shvl_pkg::*;
#(
   parameter int MAX_BUFFER_BYTES = 65535,
   parameter int OFF_W = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           data_byte,
   input  logic                 final_byte,
   output byte_class_type       byte_class,
   output logic [OFF_W-1:0]     byte_offset
);

   localparam logic [OFF_W-1:0] MAX_OFF = OFF_W'(MAX_BUFFER_BYTES);

   logic [OFF_W-1:0] offset_ff;
   logic [OFF_W-1:0] offset_in;

   always_comb begin
      offset_in = offset_ff;
      if (accept) begin
         if (final_byte) begin
            offset_in = '0;
         end else if (offset_ff < MAX_OFF) begin
            offset_in = offset_ff + OFF_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else begin
         offset_ff <= offset_in;
      end
   end

   always_comb begin
      byte_class.folded      = fold_case(data_byte);
      byte_class.blank       = (data_byte == CHAR_SPACE) || (data_byte == CHAR_TAB);
      byte_class.cr          = (data_byte == CHAR_CR);
      byte_class.lf          = (data_byte == CHAR_LF);
      byte_class.colon       = (data_byte == CHAR_COLON);
      byte_class.content     = (data_byte == CHAR_TAB) || (data_byte >= CHAR_SPACE);
      byte_class.above_space = (data_byte > CHAR_SPACE);
      byte_class.final_byte  = final_byte;
      byte_class.too_long    = (offset_ff >= MAX_OFF);
   end

   assign byte_offset = offset_ff;

endmodule

FILE: rtl/shvl_queue.sv
// ---------------------------------------------------------------------------
// SIP header value locator queue
// Short first-in first-out queue between the front end and the parser.
// ---------------------------------------------------------------------------
`include "sip_header_value_locator_assert.svh"

module shvl_queue
   import shvl_pkg::*;
#(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `SHVL_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH))
   `SHVL_ASSERT_SAME(a_pop_not_empty, clock, reset, pop, count_ff != '0)
   `SHVL_ASSERT_NEXT(a_push_grows, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)

endmodule

FILE: rtl/shvl_back.sv
// ---------------------------------------------------------------------------
// SIP header value locator parser
// Runs the header parser on classified bytes and holds the result register.
// ---------------------------------------------------------------------------
`include "sip_header_value_locator_assert.svh"

module shvl_back
   import shvl_pkg::*;
#(
   parameter int OFF_W = 16,
   parameter int LONG_STORE = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic [7:0]           long_bytes [LONG_STORE],
   input  logic                 head_valid,
   input  byte_class_type       head_class,
   input  logic [OFF_W-1:0]     head_offset,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_found,
   output logic [15:0]          rsp_value_start,
   output logic [15:0]          rsp_value_end,
   output logic                 rsp_too_long
);

   localparam int EXT_W = (OFF_W > 16) ? OFF_W : 16;
   localparam int LIDX_W = (LONG_STORE > 1) ? $clog2(LONG_STORE) : 1;

   phase_type    phase_ff;
   phase_type    phase_in;
   phase_type    work_phase;
   logic [4:0]   pos_ff;
   logic [4:0]   pos_in;
   logic         lm_ff;
   logic         lm_in;
   logic         sm_ff;
   logic         sm_in;
   logic [15:0]  vb_ff;
   logic [15:0]  vb_in;
   logic [1:0]   lbs_ff;
   logic [1:0]   lbs_in;
   logic         given_ff;

   logic         rsp_valid_ff;
   logic         found_ff;
   logic [15:0]  start_ff;
   logic [15:0]  end_ff;
   logic         too_long_ff;

   logic [15:0]  off16;
   logic         start_hit;
   logic [4:0]   cmp_pos;
   logic         fresh_name;
   logic [7:0]   long_char;
   logic [7:0]   short_char;
   logic         long_ok;
   logic         short_ok;
   logic         name_hit;
   decision_type dec;
   logic         emit_too_long;
   logic [15:0]  stop;
   logic         skip_class;
   logic         line_class;
   logic         do_cmp;
   logic         do_colon;
   logic         do_text;
   logic         emit;
   logic         out_free;

   assign off16     = 16'(head_offset);
   assign start_hit = (EXT_W'(head_offset) == EXT_W'(cfg.start_offset));

   // Name comparison: the first character of a line compares at position zero.
   assign fresh_name = (phase_ff != PH_NAME);
   assign cmp_pos    = fresh_name ? 5'd0 : pos_ff;
   assign long_char  = long_bytes[cmp_pos[LIDX_W-1:0]];
   assign short_char = cfg.short_bytes[{cmp_pos[2:0], 3'b000} +: 8];
   assign long_ok    = (cmp_pos < 5'(LONG_STORE)) && (cmp_pos < cfg.long_len) &&
                       (fold_case(long_char) == head_class.folded);
   assign short_ok   = (cmp_pos < 5'(SHORT_NAME_BYTES)) && (cmp_pos < {1'b0, cfg.short_len}) &&
                       (fold_case(short_char) == head_class.folded);
   assign name_hit   = (sm_ff && (pos_ff == {1'b0, cfg.short_len})) ||
                       (lm_ff && (pos_ff == cfg.long_len));

   always_comb begin
      phase_in      = phase_ff;
      pos_in        = pos_ff;
      lm_in         = lm_ff;
      sm_in         = sm_ff;
      vb_in         = vb_ff;
      lbs_in        = lbs_ff;
      stop          = '0;
      dec           = DEC_NONE;
      emit_too_long = 1'b0;
      work_phase    = phase_ff;
      skip_class    = 1'b0;
      line_class    = 1'b0;
      do_cmp        = 1'b0;
      do_colon      = 1'b0;
      do_text       = 1'b0;
      if (!given_ff) begin
         if (head_class.too_long) begin
            dec           = DEC_MISS;
            emit_too_long = 1'b1;
         end else begin
            if (phase_ff == PH_WAIT && start_hit) begin
               work_phase = PH_SKIP;
            end
            phase_in = work_phase;
            case (work_phase)
               PH_SKIP: begin
                  skip_class = 1'b1;
               end
               PH_SKIP_CR: begin
                  if (head_class.lf) begin
                     phase_in = PH_LINE_START;
                  end else begin
                     line_class = 1'b1;
                  end
               end
               PH_LINE_START: begin
                  line_class = 1'b1;
               end
               PH_NAME: begin
                  if (head_class.above_space && !head_class.colon) begin
                     do_cmp = 1'b1;
                  end else if (head_class.colon) begin
                     do_colon = 1'b1;
                  end else if (head_class.blank) begin
                     phase_in = PH_POST_NAME;
                  end else begin
                     skip_class = 1'b1;
                  end
               end
               PH_POST_NAME: begin
                  if (head_class.colon) begin
                     do_colon = 1'b1;
                  end else if (!head_class.blank) begin
                     skip_class = 1'b1;
                  end
               end
               PH_VAL_LWS: begin
                  if (!head_class.blank) begin
                     vb_in   = off16;
                     do_text = 1'b1;
                  end
               end
               PH_VAL_TEXT: begin
                  do_text = 1'b1;
               end
               PH_VAL_CR: begin
                  if (head_class.lf) begin
                     phase_in = PH_VAL_LF;
                     lbs_in   = 2'd2;
                  end else if (head_class.blank) begin
                     phase_in = PH_VAL_TEXT;
                  end else begin
                     stop = off16 - 16'd1;
                     dec  = DEC_HIT;
                  end
               end
               PH_VAL_LF: begin
                  if (head_class.blank) begin
                     phase_in = PH_VAL_TEXT;
                  end else begin
                     stop = off16 - {14'd0, lbs_ff};
                     dec  = DEC_HIT;
                  end
               end
               default: begin
               end
            endcase

            if (line_class) begin
               if (head_class.blank) begin
                  phase_in = PH_SKIP;
               end else if (!head_class.above_space || head_class.colon) begin
                  dec = DEC_MISS;
               end else begin
                  do_cmp   = 1'b1;
                  phase_in = PH_NAME;
               end
            end

            if (skip_class) begin
               if (head_class.content) begin
                  phase_in = PH_SKIP;
               end else if (head_class.cr) begin
                  phase_in = PH_SKIP_CR;
               end else if (head_class.lf) begin
                  phase_in = PH_LINE_START;
               end else begin
                  dec = DEC_MISS;
               end
            end

            if (do_cmp) begin
               lm_in  = (fresh_name || lm_ff) && long_ok;
               sm_in  = (fresh_name || sm_ff) && short_ok;
               pos_in = (cmp_pos < 5'd31) ? cmp_pos + 5'd1 : cmp_pos;
            end

            if (do_colon) begin
               phase_in = name_hit ? PH_VAL_LWS : PH_SKIP;
            end

            if (do_text) begin
               if (head_class.content) begin
                  phase_in = PH_VAL_TEXT;
               end else if (head_class.cr) begin
                  phase_in = PH_VAL_CR;
                  lbs_in   = 2'd1;
               end else if (head_class.lf) begin
                  phase_in = PH_VAL_LF;
                  lbs_in   = 2'd1;
               end else begin
                  stop = off16;
                  dec  = DEC_HIT;
               end
            end

            // The last byte of the buffer decides whatever is still open.
            if (dec == DEC_NONE && head_class.final_byte) begin
               case (phase_in)
                  PH_VAL_LWS: begin
                     vb_in = off16 + 16'd1;
                     stop  = off16 + 16'd1;
                     dec   = DEC_HIT;
                  end
                  PH_VAL_TEXT: begin
                     stop = off16 + 16'd1;
                     dec  = DEC_HIT;
                  end
                  PH_VAL_CR, PH_VAL_LF: begin
                     stop = off16 + 16'd1 - {14'd0, lbs_in};
                     dec  = DEC_HIT;
                  end
                  default: begin
                     dec = DEC_MISS;
                  end
               endcase
            end
         end
      end
   end

   assign emit     = (dec != DEC_NONE);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = head_valid && (!emit || out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         pos_ff   <= '0;
         lm_ff    <= 1'b1;
         sm_ff    <= 1'b1;
         vb_ff    <= '0;
         lbs_ff   <= '0;
         given_ff <= 1'b0;
      end else if (pop) begin
         if (head_class.final_byte) begin
            phase_ff <= PH_WAIT;
            pos_ff   <= '0;
            lm_ff    <= 1'b1;
            sm_ff    <= 1'b1;
            vb_ff    <= '0;
            lbs_ff   <= '0;
            given_ff <= 1'b0;
         end else begin
            phase_ff <= phase_in;
            pos_ff   <= pos_in;
            lm_ff    <= lm_in;
            sm_ff    <= sm_in;
            vb_ff    <= vb_in;
            lbs_ff   <= lbs_in;
            given_ff <= given_ff || emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         found_ff    <= (dec == DEC_HIT);
         start_ff    <= (dec == DEC_HIT) ? vb_in : 16'd0;
         end_ff      <= (dec == DEC_HIT) ? stop : 16'd0;
         too_long_ff <= emit_too_long;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = found_ff;
   assign rsp_value_start = start_ff;
   assign rsp_value_end   = end_ff;
   assign rsp_too_long    = too_long_ff;

   `SHVL_ASSERT_SAME(a_found_not_long, clock, reset, rsp_valid_ff && found_ff, !too_long_ff)
   `SHVL_ASSERT_SAME(a_miss_zero, clock, reset, rsp_valid_ff && !found_ff, start_ff == '0 && end_ff == '0)
   `SHVL_ASSERT_NEXT(a_one_result, clock, reset, pop && emit && !head_class.final_byte, given_ff)
   `SHVL_ASSERT_SAME(a_load_free, clock, reset, pop && emit, !rsp_valid_ff || !rsp_stall)

endmodule

FILE: rtl/sip_header_value_locator.sv
// ---------------------------------------------------------------------------
// SIP header value locator
// Finds a named header in a SIP message streamed one byte per transaction.
// ---------------------------------------------------------------------------
//
//   Channel  Handshake            Carries
//   req_     req_valid/req_stall  data_byte, final_byte (one message byte)
//   rsp_     rsp_valid/rsp_stall  found, value_start, value_end, too_long
//   csr_     csr_valid/csr_ready  index, data (one configuration register)
//
// One byte is taken in every cycle while the queue is not full; the parser
// state machine handles one byte per cycle unless a result is held up by
// rsp_stall, and that sets the sustained rate. The deciding byte is written
// into the queue, decided from the queue head, and rsp_valid is registered when it is popped.
// Reset is synchronous and active high; no clearing pass is needed after it.
// A stalled result holds in the output register while the parser carries on
// with bytes that give no result; bytes wait in a two-entry queue otherwise.
//
// The front end counts offsets and classifies each byte (case folding,
// blanks, line ends, colon). The parser in the back end skips the line that
// holds the start offset, compares header names against the long and the
// short name, and tracks the value through folded lines. Exactly one result
// transaction is produced per message; bytes after it are dropped until the
// final byte, after which a new message starts at offset zero.
// ---------------------------------------------------------------------------
module sip_header_value_locator
   import shvl_pkg::*;
#(
   parameter int MAX_BUFFER_BYTES = 65535,
   parameter int NAME_BYTES = 24
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_final_byte,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_found,
   output logic [15:0] rsp_value_start,
   output logic [15:0] rsp_value_end,
   output logic        rsp_too_long,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   // Offsets saturate at the buffer limit, so the counter must hold it.
   localparam int OFF_W = $clog2(MAX_BUFFER_BYTES + 1);
   // Only the long name characters that can ever match are stored.
   localparam int LONG_STORE = (NAME_BYTES < LONG_NAME_LIMIT) ? NAME_BYTES : LONG_NAME_LIMIT;
   localparam int CLASS_W = $bits(byte_class_type);
   localparam int ENTRY_W = CLASS_W + OFF_W;

   logic             csr_write;
   cfg_type          cfg_ff;
   logic [7:0]       long_ff [LONG_STORE];

   logic             req_accept;
   byte_class_type   front_class;
   logic [OFF_W-1:0] front_offset;
   logic             queue_full;
   logic             head_valid;
   logic [ENTRY_W-1:0] head_data;
   byte_class_type   head_class;
   logic [OFF_W-1:0] head_offset;
   logic             pop;

   // Configuration registers. Writes are always taken.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_LONG_LEN:  cfg_ff.long_len     <= csr_data[4:0];
            CSR_SHORT:     cfg_ff.short_bytes  <= csr_data;
            CSR_SHORT_LEN: cfg_ff.short_len    <= csr_data[3:0];
            CSR_START:     cfg_ff.start_offset <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   // Each stored long name character belongs to one of three 64-bit words.
   for (genvar i = 0; i < LONG_STORE; i++) begin : g_long
      localparam logic [2:0] WORD_IDX = (i / 8 == 0) ? CSR_LONG_LOW :
                                        (i / 8 == 1) ? CSR_LONG_MID : CSR_LONG_HIGH;
      always_ff @(posedge clock) begin
         if (reset) begin
            long_ff[i] <= '0;
         end else if (csr_write && csr_index == WORD_IDX) begin
            long_ff[i] <= csr_data[(i % 8) * 8 +: 8];
         end
      end
   end

   assign req_stall  = queue_full;
   assign req_accept = req_valid && !req_stall;

   shvl_front #(
      .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES),
      .OFF_W            (OFF_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .data_byte   (req_data_byte),
      .final_byte  (req_final_byte),
      .byte_class  (front_class),
      .byte_offset (front_offset)
   );

   shvl_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_accept),
      .push_data  ({front_class, front_offset}),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   assign head_class  = byte_class_type'(head_data[ENTRY_W-1:OFF_W]);
   assign head_offset = head_data[OFF_W-1:0];

   shvl_back #(
      .OFF_W      (OFF_W),
      .LONG_STORE (LONG_STORE)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .long_bytes      (long_ff),
      .head_valid      (head_valid),
      .head_class      (head_class),
      .head_offset     (head_offset),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_value_start (rsp_value_start),
      .rsp_value_end   (rsp_value_end),
      .rsp_too_long    (rsp_too_long)
   );

endmodule

FILE: sim/tb.sv
// ---------------------------------------------------------------------------
// SIP header value locator testbench
// Streams SIP messages through the locator byte by byte and compares every
// result transaction with a cycle-free model of the header search, under
// several name and start offset settings and several idling patterns.
// ---------------------------------------------------------------------------
module tb;
   import shvl_pkg::*;

   localparam int MAX_BUFFER  = 65535;
   localparam int CYCLE_LIMIT = 2_000_000;

   // One result of the locator, as seen on the rsp_ channel.
   typedef struct packed {
      logic        found;
      logic [15:0] value_start;
      logic [15:0] value_end;
      logic        too_long;
   } header_span_type;

   // The scoreboard follows the search one accepted byte at a time. Each
   // byte that settles the outcome of its message queues the span that the
   // block must report, and each result transaction is checked against the
   // oldest queued span.
   class locator_scoreboard;
      logic [63:0]   long_chars [3];
      logic [4:0]    long_len;
      logic [63:0]   short_chars;
      logic [3:0]    short_len;
      logic [15:0]   start_at;

      phase_type     phase;
      int unsigned   offset;
      logic [4:0]    name_pos;
      logic          long_ok;
      logic          short_ok;
      int unsigned   val_begin;
      int unsigned   val_stop;
      int unsigned   line_break;
      logic          decided;

      header_span_type expected_spans [$];
      int            errors;
      int            results;
      int            located;
      int            oversize;
      int            bytes_seen;
      int            messages;

      function new();
         long_chars[0] = '0;
         long_chars[1] = '0;
         long_chars[2] = '0;
         long_len = '0;
         short_chars = '0;
         short_len = '0;
         start_at = '0;
         errors = 0;
         results = 0;
         located = 0;
         oversize = 0;
         bytes_seen = 0;
         messages = 0;
         fresh_message();
      endfunction

      function void fresh_message();
         phase = PH_WAIT;
         offset = 0;
         name_pos = '0;
         long_ok = 1'b1;
         short_ok = 1'b1;
         val_begin = 0;
         val_stop = 0;
         line_break = 0;
         decided = 1'b0;
      endfunction

      function void write_register(csr_index_type idx, logic [63:0] v);
         case (idx)
            CSR_LONG_LOW:  long_chars[0] = v;
            CSR_LONG_MID:  long_chars[1] = v;
            CSR_LONG_HIGH: long_chars[2] = v;
            CSR_LONG_LEN:  long_len = v[4:0];
            CSR_SHORT:     short_chars = v;
            CSR_SHORT_LEN: short_len = v[3:0];
            CSR_START:     start_at = v[15:0];
            default: ;
         endcase
      endfunction

      function logic [7:0] lower(logic [7:0] c);
         if (c >= 8'h41 && c <= 8'h5a) begin
            return c + 8'd32;
         end
         return c;
      endfunction

      function logic is_blank(logic [7:0] b);
         return b == CHAR_SPACE || b == CHAR_TAB;
      endfunction

      function void compare_name(logic [7:0] b);
         logic [7:0] lb;
         lb = lower(b);
         if (name_pos >= long_len || name_pos >= 24) begin
            long_ok = 1'b0;
         end else if (lower(long_chars[name_pos[4:3]][name_pos[2:0]*8 +: 8]) != lb) begin
            long_ok = 1'b0;
         end
         if (name_pos >= short_len || name_pos >= 8) begin
            short_ok = 1'b0;
         end else if (lower(short_chars[name_pos[2:0]*8 +: 8]) != lb) begin
            short_ok = 1'b0;
         end
         if (name_pos < 31) begin
            name_pos++;
         end
      endfunction

      function decision_type skip_content(logic [7:0] b);
         if (b == CHAR_TAB || b >= CHAR_SPACE) begin
            phase = PH_SKIP;
         end else if (b == CHAR_CR) begin
            phase = PH_SKIP_CR;
         end else if (b == CHAR_LF) begin
            phase = PH_LINE_START;
         end else begin
            return DEC_MISS;
         end
         return DEC_NONE;
      endfunction

      function decision_type line_start(logic [7:0] b);
         if (is_blank(b)) begin
            phase = PH_SKIP;
            return DEC_NONE;
         end
         if (b <= CHAR_SPACE || b == CHAR_COLON) begin
            return DEC_MISS;
         end
         name_pos = '0;
         long_ok = 1'b1;
         short_ok = 1'b1;
         compare_name(b);
         phase = PH_NAME;
         return DEC_NONE;
      endfunction

      function void colon_reached();
         if ((short_ok && name_pos == short_len) || (long_ok && name_pos == long_len)) begin
            phase = PH_VAL_LWS;
         end else begin
            phase = PH_SKIP;
         end
      endfunction

      function decision_type value_text(logic [7:0] b, int unsigned off);
         if (b == CHAR_TAB || b >= CHAR_SPACE) begin
            phase = PH_VAL_TEXT;
         end else if (b == CHAR_CR) begin
            phase = PH_VAL_CR;
            line_break = 1;
         end else if (b == CHAR_LF) begin
            phase = PH_VAL_LF;
            line_break = 1;
         end else begin
            val_stop = off;
            return DEC_HIT;
         end
         return DEC_NONE;
      endfunction

      function decision_type advance(logic [7:0] b, int unsigned off);
         case (phase)
            PH_SKIP: return skip_content(b);
            PH_SKIP_CR: begin
               if (b == CHAR_LF) begin
                  phase = PH_LINE_START;
                  return DEC_NONE;
               end
               return line_start(b);
            end
            PH_LINE_START: return line_start(b);
            PH_NAME: begin
               if (b > CHAR_SPACE && b != CHAR_COLON) begin
                  compare_name(b);
                  return DEC_NONE;
               end
               if (b == CHAR_COLON) begin
                  colon_reached();
                  return DEC_NONE;
               end
               if (is_blank(b)) begin
                  phase = PH_POST_NAME;
                  return DEC_NONE;
               end
               return skip_content(b);
            end
            PH_POST_NAME: begin
               if (is_blank(b)) begin
                  return DEC_NONE;
               end
               if (b == CHAR_COLON) begin
                  colon_reached();
                  return DEC_NONE;
               end
               return skip_content(b);
            end
            PH_VAL_LWS: begin
               if (is_blank(b)) begin
                  return DEC_NONE;
               end
               val_begin = off;
               return value_text(b, off);
            end
            PH_VAL_TEXT: return value_text(b, off);
            PH_VAL_CR: begin
               if (b == CHAR_LF) begin
                  phase = PH_VAL_LF;
                  line_break = 2;
                  return DEC_NONE;
               end
               if (is_blank(b)) begin
                  phase = PH_VAL_TEXT;
                  return DEC_NONE;
               end
               val_stop = off - 1;
               return DEC_HIT;
            end
            PH_VAL_LF: begin
               if (is_blank(b)) begin
                  phase = PH_VAL_TEXT;
                  return DEC_NONE;
               end
               val_stop = off - line_break;
               return DEC_HIT;
            end
            default: return DEC_NONE;
         endcase
      endfunction

      // Notes one accepted byte and queues the span it settles, if any.
      function void track_byte(logic [7:0] b, logic last);
         int unsigned     off;
         decision_type    dec;
         header_span_type span;
         off = offset;
         dec = DEC_NONE;
         bytes_seen++;
         if (!decided) begin
            if (off >= MAX_BUFFER) begin
               span = '{found: 1'b0, value_start: '0, value_end: '0, too_long: 1'b1};
               expected_spans.push_back(span);
               decided = 1'b1;
            end else begin
               if (phase == PH_WAIT && off == start_at) begin
                  phase = PH_SKIP;
               end
               if (phase != PH_WAIT) begin
                  dec = advance(b, off);
               end
               if (dec == DEC_NONE && last) begin
                  case (phase)
                     PH_VAL_LWS: begin
                        val_begin = off + 1;
                        val_stop = off + 1;
                        dec = DEC_HIT;
                     end
                     PH_VAL_TEXT: begin
                        val_stop = off + 1;
                        dec = DEC_HIT;
                     end
                     PH_VAL_CR, PH_VAL_LF: begin
                        val_stop = off + 1 - line_break;
                        dec = DEC_HIT;
                     end
                     default: dec = DEC_MISS;
                  endcase
               end
               if (dec == DEC_HIT) begin
                  span = '{found: 1'b1, value_start: val_begin[15:0],
                           value_end: val_stop[15:0], too_long: 1'b0};
                  expected_spans.push_back(span);
                  decided = 1'b1;
               end else if (dec == DEC_MISS) begin
                  span = '{found: 1'b0, value_start: '0, value_end: '0, too_long: 1'b0};
                  expected_spans.push_back(span);
                  decided = 1'b1;
               end
            end
         end
         if (last) begin
            messages++;
            fresh_message();
         end else if (offset < MAX_BUFFER) begin
            offset++;
         end
      endfunction

      // Compares one result transaction with the oldest queued span.
      function void check_span(header_span_type got);
         header_span_type want;
         if (expected_spans.size() == 0) begin
            $display("%0t: result with nothing expected: found %0d start %0d end %0d long %0d",
                     $time, got.found, got.value_start, got.value_end, got.too_long);
            errors++;
            return;
         end
         want = expected_spans.pop_front();
         results++;
         if (want.found) located++;
         if (want.too_long) oversize++;
         if (got.found !== want.found) begin
            $display("%0t: found mismatch, expected %0d, got %0d", $time, want.found, got.found);
            errors++;
         end
         if (got.value_start !== want.value_start) begin
            $display("%0t: value_start mismatch, expected %0d, got %0d",
                     $time, want.value_start, got.value_start);
            errors++;
         end
         if (got.value_end !== want.value_end) begin
            $display("%0t: value_end mismatch, expected %0d, got %0d",
                     $time, want.value_end, got.value_end);
            errors++;
         end
         if (got.too_long !== want.too_long) begin
            $display("%0t: too_long mismatch, expected %0d, got %0d",
                     $time, want.too_long, got.too_long);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_final_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_found;
   logic [15:0] rsp_value_start;
   logic [15:0] rsp_value_end;
   logic        rsp_too_long;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = 3'd0;
   logic [63:0] csr_data = 64'd0;

   locator_scoreboard sb;
   header_span_type   seen_span;
   int                cycle_count = 0;
   int                gap_pct = 0;
   int                stall_pct = 0;
   int                settings = 0;

   // Message under construction, and the name characters currently loaded
   // into the block, kept so that headers can be made to match them.
   logic [7:0] msg [$];
   logic [7:0] long_name_chars [24];
   logic [7:0] short_name_chars [8];
   int         cfg_long_len = 0;
   int         cfg_short_len = 0;

   sip_header_value_locator dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_final_byte  (req_final_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_value_start (rsp_value_start),
      .rsp_value_end   (rsp_value_end),
      .rsp_too_long    (rsp_too_long),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // The receiver stalls at random; the rate is changed between phases.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // All sampling happens here at the rising edge, where both channels are
   // observed with the values they held going into the edge. The watchdog
   // also lives here so that a hung handshake cannot stall the run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding.",
                  cycle_count, sb.expected_spans.size());
         $display("Test completed with failures");
         $finish;
      end else if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.track_byte(req_data_byte, req_final_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            seen_span.found = rsp_found;
            seen_span.value_start = rsp_value_start;
            seen_span.value_end = rsp_value_end;
            seen_span.too_long = rsp_too_long;
            sb.check_span(seen_span);
         end
      end
   end

   // Every driving task is entered at a falling edge and returns at one.
   // The request valid is left high after a transaction so that back to
   // back bytes never see it lowered and raised within one time step.
   task automatic send_byte(logic [7:0] b, logic last);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_final_byte <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_message();
      int i;
      for (i = 0; i < msg.size(); i++) begin
         send_byte(msg[i], i == msg.size() - 1);
      end
   endtask

   // Waits until every expected result has been seen, then lets the block
   // settle, since a byte with no result may still be in the queue behind
   // the last one.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_spans.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_put(csr_index_type idx, logic [63:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_register(idx, v);
      @(negedge clock);
   endtask

   task automatic load_config(logic [63:0] lo, logic [63:0] mid, logic [63:0] hi,
                              logic [4:0] llen, logic [63:0] sname, logic [3:0] slen,
                              logic [15:0] start);
      csr_put(CSR_LONG_LOW, lo);
      csr_put(CSR_LONG_MID, mid);
      csr_put(CSR_LONG_HIGH, hi);
      csr_put(CSR_LONG_LEN, {59'd0, llen});
      csr_put(CSR_SHORT, sname);
      csr_put(CSR_SHORT_LEN, {60'd0, slen});
      csr_put(CSR_START, {48'd0, start});
      csr_valid <= 1'b0;
      settings++;
   endtask

   // A character that may stand in a header name. The wide set takes in
   // every byte above space apart from the colon.
   function automatic logic [7:0] name_char(logic wide);
      int r;
      logic [7:0] c;
      if (wide) begin
         c = 8'($urandom_range(33, 254));
         if (c >= CHAR_COLON) c = c + 8'd1;
         return c;
      end
      r = $urandom_range(0, 99);
      if (r < 40) return 8'h61 + 8'($urandom_range(0, 25));
      if (r < 80) return 8'h41 + 8'($urandom_range(0, 25));
      if (r < 90) return 8'h30 + 8'($urandom_range(0, 9));
      return 8'h2d;
   endfunction

   // Picks fresh names of the given lengths and loads all seven registers.
   // Storage beyond each name's length is filled with arbitrary bytes.
   task automatic set_names(int llen, int slen, int start, logic wide);
      logic [63:0] lw [3];
      logic [63:0] sw;
      int i;
      for (i = 0; i < 24; i++) begin
         long_name_chars[i] = (i < llen) ? name_char(wide) : 8'($urandom_range(0, 255));
         lw[i / 8][(i % 8) * 8 +: 8] = long_name_chars[i];
      end
      for (i = 0; i < 8; i++) begin
         short_name_chars[i] = (i < slen) ? name_char(wide) : 8'($urandom_range(0, 255));
         sw[i * 8 +: 8] = short_name_chars[i];
      end
      cfg_long_len = llen;
      cfg_short_len = slen;
      load_config(lw[0], lw[1], lw[2], 5'(llen), sw, 4'(slen), 16'(start));
   endtask

   function automatic void put_string(string s);
      int i;
      for (i = 0; i < s.len(); i++) msg.push_back(s[i]);
   endfunction

   function automatic void put_blanks(int n);
      int i;
      for (i = 0; i < n; i++) msg.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
   endfunction

   // Header or value text: mostly printable, with blanks and high bytes.
   function automatic void put_text(int n);
      int i;
      int r;
      for (i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 6) msg.push_back(CHAR_SPACE);
         else if (r < 10) msg.push_back(CHAR_TAB);
         else if (r < 20) msg.push_back(8'($urandom_range(128, 255)));
         else msg.push_back(8'($urandom_range(33, 126)));
      end
   endfunction

   // Mostly CR LF, but a lone CR or LF must end a line just the same.
   function automatic void put_break();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         msg.push_back(CHAR_CR);
         msg.push_back(CHAR_LF);
      end else if (r < 85) begin
         msg.push_back(CHAR_LF);
      end else begin
         msg.push_back(CHAR_CR);
      end
   endfunction

   function automatic logic [7:0] flip_case(logic [7:0] c);
      if (((c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a)) && $urandom_range(0, 1))
         return c ^ 8'h20;
      return c;
   endfunction

   // Header names: the long name or the short name in mixed case, near
   // misses of the long name, or an unrelated token.
   function automatic void put_header_name();
      int r;
      int i;
      int n;
      r = $urandom_range(0, 99);
      if (r < 35 && cfg_long_len >= 1 && cfg_long_len <= 24) begin
         for (i = 0; i < cfg_long_len; i++) msg.push_back(flip_case(long_name_chars[i]));
      end else if (r < 60 && cfg_short_len >= 1 && cfg_short_len <= 8) begin
         for (i = 0; i < cfg_short_len; i++) msg.push_back(flip_case(short_name_chars[i]));
      end else if (r < 75 && cfg_long_len >= 1 && cfg_long_len <= 24) begin
         for (i = 0; i < cfg_long_len - 1; i++) msg.push_back(flip_case(long_name_chars[i]));
         if ($urandom_range(0, 1)) begin
            msg.push_back(flip_case(long_name_chars[cfg_long_len - 1]));
            msg.push_back(name_char(1'b0));
         end
      end else begin
         n = $urandom_range(1, 10);
         for (i = 0; i < n; i++) msg.push_back(name_char(1'b0));
      end
   endfunction

   // Builds one message: a start line, a few headers with optional folded
   // continuation lines, usually a blank line and a body. Some messages are
   // pure noise, some carry a stray control byte and some are cut short.
   function automatic void build_message();
      int i;
      int n;
      int folds;
      int keep;
      msg.delete();
      if ($urandom_range(0, 99) < 12) begin
         n = $urandom_range(1, 40);
         for (i = 0; i < n; i++) msg.push_back(8'($urandom_range(0, 255)));
         return;
      end
      put_text($urandom_range(0, 12));
      put_break();
      n = $urandom_range(0, 4);
      for (i = 0; i < n; i++) begin
         put_header_name();
         if ($urandom_range(0, 99) < 20) put_blanks($urandom_range(1, 2));
         msg.push_back(CHAR_COLON);
         put_blanks($urandom_range(0, 2));
         put_text($urandom_range(0, 10));
         folds = 0;
         while (folds < 2 && $urandom_range(0, 99) < 20) begin
            put_break();
            put_blanks($urandom_range(1, 2));
            put_text($urandom_range(0, 6));
            folds++;
         end
         put_break();
      end
      if ($urandom_range(0, 99) < 65) begin
         put_break();
         put_text($urandom_range(0, 8));
      end
      if ($urandom_range(0, 99) < 8) begin
         msg.insert($urandom_range(0, msg.size() - 1), 8'($urandom_range(0, 31)));
      end
      if ($urandom_range(0, 99) < 25) begin
         keep = $urandom_range(1, msg.size());
         while (msg.size() > keep) void'(msg.pop_back());
      end
   endfunction

   initial begin
      int mode;
      int k;
      int phase_bytes;
      sb = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed messages, searched for "via" with the compact form "v".
      load_config(64'h0000_0000_0061_6976, 64'd0, 64'd0, 5'd3,
                  64'h0000_0000_0000_0076, 4'd1, 16'd0);
      // The value is empty because the buffer ends on the blank after the
      // colon; the start line ends on a lone LF.
      put_string("R");
      msg.push_back(CHAR_LF);
      put_string("v:");
      msg.push_back(CHAR_TAB);
      send_message();
      // A lone CR ends the start line, the name differs in case and has a
      // blank before the colon, and the trailing CR is left out of the value.
      msg.delete();
      put_string("R");
      msg.push_back(CHAR_CR);
      put_string("VIA :b");
      msg.push_back(CHAR_CR);
      send_message();
      // A blank line ends the search before any header is found.
      msg.delete();
      put_string("R");
      msg.push_back(CHAR_LF);
      msg.push_back(CHAR_CR);
      msg.push_back(CHAR_LF);
      send_message();
      // A single top-value byte that is also the last one.
      msg.delete();
      msg.push_back(8'hff);
      send_message();
      drain();

      // Lengths beyond what the registers can hold never match, and a start
      // offset at the top of its range lies beyond the buffer.
      load_config('1, '1, '1, 5'd31, 64'd0, 4'd15, 16'hffff);
      msg.delete();
      put_string("R");
      msg.push_back(CHAR_LF);
      put_string("via:x");
      send_message();
      drain();

      // Random messages under four idling patterns, two settings each.
      for (mode = 0; mode < 4; mode++) begin
         for (k = 0; k < 2; k++) begin
            case (mode)
               0: begin gap_pct = 0;  stall_pct = 0;  end
               1: begin gap_pct = 85; stall_pct = 0;  end
               2: begin gap_pct = 0;  stall_pct = 85; end
               default: begin gap_pct = 25; stall_pct = 25; end
            endcase
            case (mode * 2 + k)
               0: set_names(24, 8, 0, 1'b0);
               1: set_names($urandom_range(1, 23), $urandom_range(1, 7), 0, 1'b0);
               2: set_names(0, $urandom_range(1, 8), 0, 1'b0);
               3: set_names($urandom_range(1, 24), 0, $urandom_range(0, 30), 1'b0);
               4: set_names($urandom_range(1, 24), $urandom_range(1, 8), 0, 1'b1);
               5: set_names($urandom_range(1, 24), $urandom_range(1, 8),
                            $urandom_range(0, 60), 1'b0);
               6: set_names(1, 1, 0, 1'b0);
               default: set_names($urandom_range(1, 24), $urandom_range(1, 8), 0, 1'b1);
            endcase
            phase_bytes = 0;
            while (phase_bytes < 210) begin
               build_message();
               phase_bytes += msg.size();
               send_message();
            end
            drain();
         end
      end

      repeat (12) @(posedge clock);
      $display("Streamed %0d bytes in %0d messages under %0d register settings.",
               sb.bytes_seen, sb.messages, settings);
      $display("Checked %0d results: %0d headers located, %0d oversize buffers.",
               sb.results, sb.located, sb.oversize);
      if (sb.errors == 0 && sb.expected_spans.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
